[rtl/linear_row_bound_tightening_macros.svh]
// Assertion macros for the linear row bound tightening block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LINEAR_ROW_BOUND_TIGHTENING_MACROS_SVH
`define LINEAR_ROW_BOUND_TIGHTENING_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LRBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRBT_ASSERT_IMP(lbl, ante, cons, msg)
`define LRBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/lrbt_pkg.sv]
// Shared types, codes and checked 64-bit add/subtract helpers for the
// linear row bound tightening block. No dependencies.
`default_nettype none

package lrbt_pkg;

  localparam int unsigned NumVariables = 1024;
  localparam int unsigned MaxRowTerms  = 16;
  localparam int unsigned SlotW        = 10;
  localparam int unsigned CoefW        = 55;
  localparam int unsigned ValW         = 64;
  localparam int unsigned PassW        = 16;
  localparam int unsigned StatW        = 3;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TERM = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_CHANGE = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic {
    SIDE_LOW  = 1'b0,
    SIDE_HIGH = 1'b1
  } side_e;

  typedef enum logic [StatW-1:0] {
    STAT_PROCESSED = 3'd0,
    STAT_REDUNDANT = 3'd1,
    STAT_ROW_CONTRA = 3'd2,
    STAT_VAR_CONTRA = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
    logic      ceil_mode;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P1_RD,
    ST_P1_MA_GO,
    ST_P1_MA_W,
    ST_P1_MB_GO,
    ST_P1_MB_W,
    ST_P1_ACC,
    ST_CHECK,
    ST_P2_RD,
    ST_P2_LD,
    ST_P2_SUB1,
    ST_P2_SUB2,
    ST_P2_DIV_GO,
    ST_P2_DIV_W,
    ST_P2_CHK,
    ST_P3_RD,
    ST_P3_LO,
    ST_P3_HI,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic            ovf;
    logic [ValW-1:0] val;
  } chk_t;

  function automatic chk_t chk_add(input logic signed [ValW-1:0] a,
                                   input logic signed [ValW-1:0] b);
    chk_t r;
    r.val = a + b;
    r.ovf = (a[ValW-1] == b[ValW-1]) && (r.val[ValW-1] != a[ValW-1]);
    return r;
  endfunction

  function automatic chk_t chk_sub(input logic signed [ValW-1:0] a,
                                   input logic signed [ValW-1:0] b);
    chk_t r;
    r.val = a - b;
    r.ovf = (a[ValW-1] != b[ValW-1]) && (r.val[ValW-1] != a[ValW-1]);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/linear_row_bound_tightening.sv]
// Linear row bound tightening: bound memories, term store and row sequencer.
// Loads and non-last terms give no word. For a last term of a row with a
// side, activities come first (two multiplies per term), then, unless the
// check ends the row, propagation (up to two divides per term in the shared
// arithmetic unit), then write-back per term plus output stalls. No input is
// taken until the status word is out. Reset clears control state and
// counters; the bound memories are not cleared. Depends on lrbt_pkg and lrbt_arith.
`default_nettype none
`include "linear_row_bound_tightening_macros.svh"

module linear_row_bound_tightening import lrbt_pkg::*; #(
  parameter int unsigned NUM_VARIABLES = NumVariables,
  parameter int unsigned MAX_ROW_TERMS = MaxRowTerms
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic [SlotW-1:0]        slot_i,
  input  logic signed [CoefW-1:0] coefficient_i,
  input  logic signed [ValW-1:0]  value_low_i,
  input  logic signed [ValW-1:0]  value_high_i,
  input  logic                    has_row_low_i,
  input  logic                    has_row_high_i,
  input  logic                    last_term_i,
  input  logic [PassW-1:0]        pass_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    kind_o,
  output logic [SlotW-1:0]        change_slot_o,
  output logic                    side_o,
  output logic signed [ValW-1:0]  old_bound_o,
  output logic signed [ValW-1:0]  new_bound_o,
  output logic [StatW-1:0]        row_status_o,
  output logic                    any_change_o,
  output logic [PassW-1:0]        pass_echo_o,
  output logic                    last_o
);

  localparam int unsigned AddrW = $clog2(NUM_VARIABLES);
  localparam int unsigned CntW  = $clog2(MAX_ROW_TERMS + 1);
  localparam int unsigned IdxW  = (MAX_ROW_TERMS > 1) ? $clog2(MAX_ROW_TERMS) : 1;

  function automatic logic [SlotW-1:0] reduce_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    r = s;
    for (int k = SlotW - 1; k >= 0; k--) begin
      if ((64'(NUM_VARIABLES) << k) < (64'd1 << SlotW)) begin
        if (r >= SlotW'(64'(NUM_VARIABLES) << k)) begin
          r = r - SlotW'(64'(NUM_VARIABLES) << k);
        end
      end
    end
    return r;
  endfunction

  // bound memories
  logic signed [ValW-1:0] lo_mem [NUM_VARIABLES];
  logic signed [ValW-1:0] hi_mem [NUM_VARIABLES];
  logic signed [ValW-1:0] lo_rd_q, hi_rd_q;

  // term store
  logic [SlotW-1:0]        slot_q [MAX_ROW_TERMS];
  logic signed [CoefW-1:0] coef_q [MAX_ROW_TERMS];
  logic signed [ValW-1:0]  tmin_q [MAX_ROW_TERMS];
  logic signed [ValW-1:0]  tmax_q [MAX_ROW_TERMS];
  logic signed [ValW-1:0]  plo_q  [MAX_ROW_TERMS];
  logic signed [ValW-1:0]  phi_q  [MAX_ROW_TERMS];

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, n_q;
  logic [IdxW-1:0]        idx_q;
  logic                   ovf_q, any_q, side_q;
  status_e                status_q;
  logic signed [ValW-1:0] act_min_q, act_max_q;
  logic signed [ValW-1:0] rlo_q, rhi_q, a_q, t_q, rhs_q, nl_q, nu_q;
  logic                   hl_q, hh_q;
  logic [PassW-1:0]       pass_q;
  logic [SlotW-1:0]       vslot_q;

  logic                   out_valid_q;
  kind_e                  out_kind_q;
  logic [SlotW-1:0]       out_slot_q;
  logic                   out_side_q;
  logic signed [ValW-1:0] out_old_q, out_new_q;
  status_e                out_stat_q;
  logic                   out_any_q, out_last_q;
  logic [PassW-1:0]       out_pass_q;

  logic                    in_acc, is_load, is_term, stored, last_idx, out_free;
  logic [SlotW-1:0]        in_slot;
  logic [CntW-1:0]         cnt_inc;
  logic [AddrW-1:0]        rd_addr, wr_addr;
  logic                    lo_we, hi_we, out_load;
  logic signed [ValW-1:0]  lo_wdata, hi_wdata;
  logic signed [CoefW-1:0] cur_coef;
  logic                    cpos, raise_low, lo_diff, hi_diff, contra, redundant;
  logic signed [ValW-1:0]  pmin, pmax;
  chk_t                    add_lo, add_hi, sub1, sub2;

  arith_req_t             arith_req;
  arith_rsp_t             arith_rsp;
  logic signed [ValW-1:0] arith_x, arith_res;

  lrbt_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .x_i    (arith_x),
    .y_i    (cur_coef),
    .rsp_o  (arith_rsp),
    .res_o  (arith_res)
  );

  always_comb begin
    in_acc   = in_valid_i && (state_q == ST_IDLE);
    is_load  = (cmd_e'(command_i) == CMD_LOAD);
    is_term  = (cmd_e'(command_i) == CMD_TERM);
    in_slot  = reduce_slot(slot_i);
    stored   = (cnt_q < CntW'(MAX_ROW_TERMS));
    cnt_inc  = cnt_q + CntW'(stored);
    last_idx = (CntW'(idx_q) == (n_q - 1'b1));
    out_free = !out_valid_q || !out_stall_i;
    rd_addr  = AddrW'(slot_q[idx_q]);
    cur_coef = coef_q[idx_q];
    cpos     = !cur_coef[CoefW-1] && (cur_coef != '0);
    raise_low = cpos ^ side_q;
    lo_diff  = (plo_q[idx_q] != lo_rd_q);
    hi_diff  = (phi_q[idx_q] != hi_rd_q);
    pmin     = (a_q < arith_res) ? a_q : arith_res;
    pmax     = (a_q < arith_res) ? arith_res : a_q;
    add_lo   = chk_add(act_min_q, pmin);
    add_hi   = chk_add(act_max_q, pmax);
    sub1     = side_q ? chk_sub(act_min_q, tmin_q[idx_q])
                      : chk_sub(act_max_q, tmax_q[idx_q]);
    sub2     = chk_sub(side_q ? rhi_q : rlo_q, t_q);
    contra   = (hl_q && (act_max_q < rlo_q)) || (hh_q && (act_min_q > rhi_q));
    redundant = (!hl_q || (act_min_q >= rlo_q)) && (!hh_q || (act_max_q <= rhi_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_term && last_term_i) begin
          state_d = (!has_row_low_i && !has_row_high_i) ? ST_STATUS : ST_P1_RD;
        end
      end
      ST_P1_RD:    state_d = ST_P1_MA_GO;
      ST_P1_MA_GO: state_d = ST_P1_MA_W;
      ST_P1_MA_W:  if (arith_rsp.done) state_d = ST_P1_MB_GO;
      ST_P1_MB_GO: state_d = ST_P1_MB_W;
      ST_P1_MB_W:  if (arith_rsp.done) state_d = ST_P1_ACC;
      ST_P1_ACC:   state_d = last_idx ? ST_CHECK : ST_P1_RD;
      ST_CHECK:    state_d = (ovf_q || contra || redundant) ? ST_STATUS : ST_P2_RD;
      ST_P2_RD:    state_d = ST_P2_LD;
      ST_P2_LD:    state_d = ST_P2_SUB1;
      ST_P2_SUB1:  state_d = ST_P2_SUB2;
      ST_P2_SUB2:  state_d = ST_P2_DIV_GO;
      ST_P2_DIV_GO: state_d = ST_P2_DIV_W;
      ST_P2_DIV_W: begin
        if (arith_rsp.done) begin
          state_d = (!side_q && hh_q) ? ST_P2_SUB1 : ST_P2_CHK;
        end
      end
      ST_P2_CHK: begin
        if (ovf_q || (nl_q > nu_q)) begin
          state_d = ST_STATUS;
        end else begin
          state_d = last_idx ? ST_P3_RD : ST_P2_RD;
        end
      end
      ST_P3_RD: state_d = ST_P3_LO;
      ST_P3_LO: if (!lo_diff || out_free) state_d = ST_P3_HI;
      ST_P3_HI: begin
        if (!hi_diff || out_free) begin
          state_d = last_idx ? ST_STATUS : ST_P3_RD;
        end
      end
      ST_STATUS: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    arith_req = '{start: 1'b0, op: OP_MUL, ceil_mode: 1'b0};
    arith_x   = rhs_q;
    lo_we     = 1'b0;
    hi_we     = 1'b0;
    out_load  = 1'b0;
    wr_addr   = rd_addr;
    lo_wdata  = plo_q[idx_q];
    hi_wdata  = phi_q[idx_q];
    case (state_q)
      ST_IDLE: begin
        lo_we    = in_acc && is_load;
        hi_we    = in_acc && is_load;
        wr_addr  = AddrW'(in_slot);
        lo_wdata = value_low_i;
        hi_wdata = value_high_i;
      end
      ST_P1_MA_GO: begin
        arith_req.start = 1'b1;
        arith_x         = lo_rd_q;
      end
      ST_P1_MB_GO: begin
        arith_req.start = 1'b1;
        arith_x         = hi_rd_q;
      end
      ST_P2_DIV_GO: begin
        arith_req = '{start: 1'b1, op: OP_DIV, ceil_mode: side_q ? !cpos : cpos};
      end
      ST_P3_LO: begin
        out_load = lo_diff && out_free;
        lo_we    = lo_diff && out_free;
      end
      ST_P3_HI: begin
        out_load = hi_diff && out_free;
        hi_we    = hi_diff && out_free;
      end
      ST_STATUS: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lo_we) begin
      lo_mem[wr_addr] <= lo_wdata;
    end
    lo_rd_q <= lo_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hi_we) begin
      hi_mem[wr_addr] <= hi_wdata;
    end
    hi_rd_q <= hi_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      any_q       <= 1'b0;
      side_q      <= SIDE_LOW;
      status_q    <= STAT_PROCESSED;
      act_min_q   <= '0;
      act_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_term) begin
            cnt_q <= last_term_i ? '0 : cnt_inc;
            if (last_term_i) begin
              n_q       <= cnt_inc;
              idx_q     <= '0;
              ovf_q     <= 1'b0;
              any_q     <= 1'b0;
              act_min_q <= '0;
              act_max_q <= '0;
              status_q  <= (!has_row_low_i && !has_row_high_i) ? STAT_REDUNDANT
                                                               : STAT_PROCESSED;
            end
          end
        end
        ST_P1_MA_W, ST_P1_MB_W: begin
          if (arith_rsp.done) ovf_q <= ovf_q | arith_rsp.ovf;
        end
        ST_P1_ACC: begin
          act_min_q <= add_lo.val;
          act_max_q <= add_hi.val;
          ovf_q     <= ovf_q | add_lo.ovf | add_hi.ovf;
          if (!last_idx) idx_q <= idx_q + 1'b1;
        end
        ST_CHECK: begin
          idx_q <= '0;
          if (ovf_q) begin
            status_q <= STAT_OVERFLOW;
          end else if (contra) begin
            status_q <= STAT_ROW_CONTRA;
          end else if (redundant) begin
            status_q <= STAT_REDUNDANT;
          end
        end
        ST_P2_LD:   side_q <= hl_q ? SIDE_LOW : SIDE_HIGH;
        ST_P2_SUB1: ovf_q <= ovf_q | sub1.ovf;
        ST_P2_SUB2: ovf_q <= ovf_q | sub2.ovf;
        ST_P2_DIV_W: begin
          if (arith_rsp.done) begin
            ovf_q <= ovf_q | arith_rsp.ovf;
            if (!side_q && hh_q) side_q <= SIDE_HIGH;
          end
        end
        ST_P2_CHK: begin
          if (ovf_q) begin
            status_q <= STAT_OVERFLOW;
          end else if (nl_q > nu_q) begin
            status_q <= STAT_VAR_CONTRA;
          end else begin
            idx_q <= last_idx ? '0 : idx_q + 1'b1;
          end
        end
        ST_P3_LO: if (out_load) any_q <= 1'b1;
        ST_P3_HI: begin
          if (out_load) any_q <= 1'b1;
          if ((!hi_diff || out_free) && !last_idx) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_term) begin
          if (stored) begin
            slot_q[cnt_q[IdxW-1:0]] <= in_slot;
            coef_q[cnt_q[IdxW-1:0]] <= coefficient_i;
          end
          if (last_term_i) begin
            rlo_q  <= value_low_i;
            rhi_q  <= value_high_i;
            hl_q   <= has_row_low_i;
            hh_q   <= has_row_high_i;
            pass_q <= pass_index_i;
          end
        end
      end
      ST_P1_MA_W: if (arith_rsp.done) a_q <= arith_res;
      ST_P1_ACC: begin
        tmin_q[idx_q] <= pmin;
        tmax_q[idx_q] <= pmax;
      end
      ST_P2_LD: begin
        nl_q <= lo_rd_q;
        nu_q <= hi_rd_q;
      end
      ST_P2_SUB1: t_q   <= sub1.val;
      ST_P2_SUB2: rhs_q <= sub2.val;
      ST_P2_DIV_W: begin
        if (arith_rsp.done) begin
          if (raise_low) begin
            if (arith_res > nl_q) nl_q <= arith_res;
          end else begin
            if (arith_res < nu_q) nu_q <= arith_res;
          end
        end
      end
      ST_P2_CHK: begin
        plo_q[idx_q] <= nl_q;
        phi_q[idx_q] <= nu_q;
        vslot_q      <= slot_q[idx_q];
      end
      default: ;
    endcase

    if (out_load) begin
      out_pass_q <= pass_q;
      if (state_q == ST_STATUS) begin
        out_kind_q <= KIND_STATUS;
        out_slot_q <= (status_q == STAT_VAR_CONTRA) ? vslot_q : '0;
        out_side_q <= SIDE_LOW;
        out_old_q  <= '0;
        out_new_q  <= '0;
        out_stat_q <= status_q;
        out_any_q  <= any_q;
        out_last_q <= 1'b1;
      end else begin
        out_kind_q <= KIND_CHANGE;
        out_slot_q <= slot_q[idx_q];
        out_stat_q <= STAT_PROCESSED;
        out_any_q  <= 1'b0;
        out_last_q <= 1'b0;
        if (state_q == ST_P3_LO) begin
          out_side_q <= SIDE_LOW;
          out_old_q  <= lo_rd_q;
          out_new_q  <= plo_q[idx_q];
        end else begin
          out_side_q <= SIDE_HIGH;
          out_old_q  <= hi_rd_q;
          out_new_q  <= phi_q[idx_q];
        end
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign change_slot_o = out_slot_q;
  assign side_o        = out_side_q;
  assign old_bound_o   = out_old_q;
  assign new_bound_o   = out_new_q;
  assign row_status_o  = out_stat_q;
  assign any_change_o  = out_any_q;
  assign pass_echo_o   = out_pass_q;
  assign last_o        = out_last_q;

  `LRBT_ASSERT_IMP(a_arith_idle, arith_req.start, !arith_rsp.busy, "arith start while busy")
  `LRBT_ASSERT_IMP(a_out_no_drop, out_load, !out_valid_q || !out_stall_i, "output word overwritten")
  `LRBT_ASSERT_IMP(a_wb_clean, (lo_we || hi_we) && (state_q != ST_IDLE), !ovf_q && (status_q == STAT_PROCESSED), "bound write-back on failed row")
  `LRBT_ASSERT_NEXT(a_status_ends, out_load && (state_q == ST_STATUS), state_q == ST_IDLE, "status word did not end row")

endmodule

`default_nettype wire

[rtl/lrbt_arith.sv]
// Shared multi-cycle arithmetic unit: checked 64x55 signed multiply
// (four 32x32 partial products) and floor/ceil division (radix 2).
// Depends on lrbt_pkg.
`default_nettype none

module lrbt_arith import lrbt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  arith_req_t             req_i,
  input  logic signed [ValW-1:0] x_i,
  input  logic signed [CoefW-1:0] y_i,
  output arith_rsp_t             rsp_o,
  output logic signed [ValW-1:0] res_o
);

  localparam int unsigned MulSteps = 4;
  localparam int unsigned DivSteps = ValW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned AccW     = 2 * ValW;
  localparam int unsigned HalfW    = ValW / 2;

  logic                  busy_q, done_q, ovf_q;
  arith_op_e             op_q;
  logic                  ceil_q, neg_q, dz_q;
  logic [CntW-1:0]       cnt_q;
  logic [ValW-1:0]       ma_q, mb_q;
  logic [AccW-1:0]       acc_q;
  logic [CoefW-1:0]      rem_q;
  logic signed [ValW-1:0] res_q;

  logic [ValW-1:0]  xu, mag_x;
  logic [CoefW-1:0] yu, mag_y;
  logic [HalfW-1:0] pa, pb;
  logic [ValW-1:0]  pp;
  logic [AccW-1:0]  pp_sh, acc_sum;
  logic [ValW-1:0]  lowp, mres;
  logic             movf;
  logic [CoefW:0]   t, diff, dv;
  logic             ge, adj, dovf;
  logic [CoefW-1:0] rem_next;
  logic [ValW-1:0]  q_next, qa, dres;
  logic             last_step;

  always_comb begin
    xu    = x_i;
    mag_x = xu[ValW-1] ? (~xu + 1'b1) : xu;
    yu    = y_i;
    mag_y = yu[CoefW-1] ? (~yu + 1'b1) : yu;

    // multiply step: partial product selected by cnt_q
    pa = cnt_q[1] ? ma_q[ValW-1:HalfW] : ma_q[HalfW-1:0];
    pb = cnt_q[0] ? mb_q[ValW-1:HalfW] : mb_q[HalfW-1:0];
    pp = pa * pb;
    if (cnt_q[1] && cnt_q[0]) begin
      pp_sh = {pp, {ValW{1'b0}}};
    end else if (cnt_q[1] || cnt_q[0]) begin
      pp_sh = {{HalfW{1'b0}}, pp, {HalfW{1'b0}}};
    end else begin
      pp_sh = {{ValW{1'b0}}, pp};
    end
    acc_sum = acc_q + pp_sh;
    lowp    = acc_sum[ValW-1:0];
    movf    = (|acc_sum[AccW-1:ValW]) ||
              (neg_q ? (lowp > {1'b1, {(ValW-1){1'b0}}}) : lowp[ValW-1]);
    mres    = neg_q ? (~lowp + 1'b1) : lowp;

    // divide step: restoring, one quotient bit per cycle
    dv       = mb_q[CoefW:0];
    t        = {rem_q, ma_q[ValW-1]};
    ge       = (t >= dv);
    diff     = t - dv;
    rem_next = ge ? diff[CoefW-1:0] : t[CoefW-1:0];
    q_next   = {ma_q[ValW-2:0], ge};
    // nonzero remainder rounds the magnitude up for floor of a negative
    // quotient or ceil of a positive one
    adj      = (|rem_next) && (ceil_q ^ neg_q);
    qa       = q_next + ValW'(adj);
    dovf     = dz_q || (!neg_q && qa[ValW-1]);
    dres     = neg_q ? (~qa + 1'b1) : qa;

    last_step = (op_q == OP_MUL) ? (cnt_q == CntW'(MulSteps - 1))
                                 : (cnt_q == CntW'(DivSteps - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= busy_q && last_step;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      ceil_q <= req_i.ceil_mode;
      neg_q  <= xu[ValW-1] ^ yu[CoefW-1];
      dz_q   <= (yu == '0);
      ma_q   <= mag_x;
      mb_q   <= ValW'(mag_y);
      acc_q  <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        acc_q <= acc_sum;
        if (last_step) begin
          res_q <= mres;
          ovf_q <= movf;
        end
      end else begin
        ma_q  <= q_next;
        rem_q <= rem_next;
        if (last_step) begin
          res_q <= dres;
          ovf_q <= dovf;
        end
      end
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, ovf: ovf_q};
  assign res_o = res_q;

endmodule

`default_nettype wire
